### hw/rtl/teoq_pkg.sv
`default_nettype none

package teoq_pkg;

  // Status codes returned with every result.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusFullDrop  = 2'd1;
  localparam logic [1:0] StatusEmptyPop  = 2'd2;

  // Request codes carried in the mode field.
  localparam logic ModeInsert = 1'b0;
  localparam logic ModePop    = 1'b1;

  // Broadcast command seen by every cell in the same cycle.
  typedef struct packed {
    logic ins;  // insert the broadcast event
    logic pop;  // remove the head entry
  } teoq_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/time_ordered_event_queue.sv
// Time-ordered pending-event list for a discrete-event scheduler.
// The slave channel takes one request per item: tuser carries the mode (0
// inserts an event, 1 pops the head) and the event kind, tdata the event time.
// The master channel returns exactly one result per request: tdata holds the
// new head time and tuser the head kind, an empty flag and a status (ok, insert
// dropped because the list is full, or pop on an empty list; both of the latter
// leave the list unchanged). Head time and kind read zero when the list is
// empty. Events with equal times leave last-in-first-out.
// The list is a row of QUEUE_DEPTH identical cells; each request is broadcast
// to all cells, which compare and shift in the same cycle, so one request is
// taken per clock. Its result sits in the output register in the cycle after
// acceptance. The output register lets a new request in whenever it is empty
// or being drained in that cycle, so back-to-back requests keep full rate as
// long as the receiver keeps m_axis_tready_i high. When the receiver stalls,
// the result holds and s_axis_tready_o drops until it is taken.
// Reset empties the list at once and clears the output valid; no clearing
// pass is needed, as each cell carries its own valid flag.
`default_nettype none

module time_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_WIDTH  = 32,
  localparam int unsigned InWidth    = ((TIME_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutWidth   = ((TIME_WIDTH + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // From bit 0: event_time (TIME_WIDTH), zero pad.
  input  wire logic [InWidth-1:0]  s_axis_tdata_i,
  // From bit 0: mode (1), event_kind (1).
  input  wire logic [1:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // From bit 0: head_time (TIME_WIDTH), zero pad.
  output logic [OutWidth-1:0]      m_axis_tdata_o,
  // From bit 0: head_kind (1), is_empty (1), status (2).
  output logic [3:0]               m_axis_tuser_o
);

  // Unpacked request fields.
  logic                  req_mode;
  logic [TIME_WIDTH-1:0] req_time;
  logic                  req_kind;

  assign req_mode = s_axis_tuser_i[0];
  assign req_time = s_axis_tdata_i[TIME_WIDTH-1:0];
  assign req_kind = s_axis_tuser_i[1];

  // Cell outputs.
  logic                  cell_ge         [QUEUE_DEPTH];
  logic                  cell_valid      [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] cell_time       [QUEUE_DEPTH];
  logic                  cell_kind       [QUEUE_DEPTH];
  logic                  cell_valid_next [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] cell_time_next  [QUEUE_DEPTH];
  logic                  cell_kind_next  [QUEUE_DEPTH];

  logic                 accept;
  logic                 list_full;
  logic                 list_empty;
  teoq_pkg::teoq_ctrl_t ctrl;
  logic [1:0]           status;

  // Occupied slots are always the lowest ones, so the ends tell the fill.
  assign list_full  = cell_valid[QUEUE_DEPTH-1];
  assign list_empty = !cell_valid[0];

  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.pop = 1'b0;
    status   = teoq_pkg::StatusOk;
    if (accept) begin
      if (req_mode == teoq_pkg::ModeInsert) begin
        if (list_full) begin
          status = teoq_pkg::StatusFullDrop;
        end else begin
          ctrl.ins = 1'b1;
        end
      end else begin
        if (list_empty) begin
          status = teoq_pkg::StatusEmptyPop;
        end else begin
          ctrl.pop = 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  left_valid;
    logic [TIME_WIDTH-1:0] left_time;
    logic                  left_kind;
    logic                  left_ge;
    logic                  right_valid;
    logic [TIME_WIDTH-1:0] right_time;
    logic                  right_kind;

    if (i == 0) begin : g_first
      // Nothing lies ahead of the head slot.
      assign left_valid = 1'b0;
      assign left_time  = '0;
      assign left_kind  = 1'b0;
      assign left_ge    = 1'b0;
    end else begin : g_mid_left
      assign left_valid = cell_valid[i-1];
      assign left_time  = cell_time[i-1];
      assign left_kind  = cell_kind[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      // A pop empties the tail slot.
      assign right_valid = 1'b0;
      assign right_time  = '0;
      assign right_kind  = 1'b0;
    end else begin : g_mid_right
      assign right_valid = cell_valid[i+1];
      assign right_time  = cell_time[i+1];
      assign right_kind  = cell_kind[i+1];
    end

    teoq_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_time_i    (req_time),
      .new_kind_i    (req_kind),
      .left_valid_i  (left_valid),
      .left_time_i   (left_time),
      .left_kind_i   (left_kind),
      .left_ge_i     (left_ge),
      .right_valid_i (right_valid),
      .right_time_i  (right_time),
      .right_kind_i  (right_kind),
      .ge_o          (cell_ge[i]),
      .valid_o       (cell_valid[i]),
      .time_o        (cell_time[i]),
      .kind_o        (cell_kind[i]),
      .valid_next_o  (cell_valid_next[i]),
      .time_next_o   (cell_time_next[i]),
      .kind_next_o   (cell_kind_next[i])
    );
  end

  // Output register: the head as it stands after the accepted request.
  logic                  out_valid_q;
  logic [TIME_WIDTH-1:0] out_time_q;
  logic                  out_kind_q;
  logic                  out_empty_q;
  logic [1:0]            out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      // An empty list reports zero time and kind whatever the slot holds.
      out_time_q   <= cell_valid_next[0] ? cell_time_next[0] : '0;
      out_kind_q   <= cell_valid_next[0] && cell_kind_next[0];
      out_empty_q  <= !cell_valid_next[0];
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutWidth'(out_time_q);
  assign m_axis_tuser_o  = {out_status_q, out_empty_q, out_kind_q};

endmodule

`default_nettype wire

### hw/rtl/teoq_cell.sv
`default_nettype none

// One slot of the sorted list. On an insert the cell keeps its entry, takes
// the new event, or takes its left neighbor's entry; on a pop it takes its
// right neighbor's entry.
module teoq_cell #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire teoq_pkg::teoq_ctrl_t  ctrl_i,
  input  wire logic [TIME_WIDTH-1:0] new_time_i,
  input  wire logic                  new_kind_i,
  input  wire logic                  left_valid_i,
  input  wire logic [TIME_WIDTH-1:0] left_time_i,
  input  wire logic                  left_kind_i,
  input  wire logic                  left_ge_i,
  input  wire logic                  right_valid_i,
  input  wire logic [TIME_WIDTH-1:0] right_time_i,
  input  wire logic                  right_kind_i,
  output logic                       ge_o,
  output logic                       valid_o,
  output logic [TIME_WIDTH-1:0]      time_o,
  output logic                       kind_o,
  output logic                       valid_next_o,
  output logic [TIME_WIDTH-1:0]      time_next_o,
  output logic                       kind_next_o
);

  logic                  valid_q, valid_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic                  kind_q, kind_d;

  // An empty slot counts as later than any event, so the new event lands
  // in the first empty slot when it is later than everything stored.
  assign ge_o = !valid_q || (time_q >= new_time_i);

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    kind_d  = kind_q;
    if (ctrl_i.ins && ge_o) begin
      if (left_ge_i) begin
        valid_d = left_valid_i;
        time_d  = left_time_i;
        kind_d  = left_kind_i;
      end else begin
        valid_d = 1'b1;
        time_d  = new_time_i;
        kind_d  = new_kind_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      time_d  = right_time_i;
      kind_d  = right_kind_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    kind_q <= kind_d;
  end

  assign valid_o      = valid_q;
  assign time_o       = time_q;
  assign kind_o       = kind_q;
  assign valid_next_o = valid_d;
  assign time_next_o  = time_d;
  assign kind_next_o  = kind_d;

endmodule

`default_nettype wire
